[hdl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/wsd_pkg.sv]
// Types and constants shared by the deframer modules.
`timescale 1ns / 1ps
package wsd_pkg;

  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam int unsigned TDATA_W = 80;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  payload;
    logic        last;
  } result_t;

endpackage

[hdl/websocket_frame_deframer.sv]
// WebSocket receive-side frame deframer: header parse and payload unmasking.
// A byte taken into the input register passes through the single-pass parser, which is
// combinational, into the output buffer, whose head entry drives the output stream.
// Throughput: one byte per cycle while the output buffer has room, set by that parser.
// A header or key byte that completes no descriptor produces no result at all.
// Reset (rst, synchronous, active high) clears the parse state and empties both stages.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module websocket_frame_deframer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] frame_fin, [4:1] frame_opcode, [5] frame_masked, [69:6] frame_length,
  // [77:70] payload_byte, [79:78] zero
  output logic [wsd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,  // [0] result_kind
  output logic                        m_axis_tlast   // frame_last
);
  import wsd_pkg::*;

  // Input register. It takes a new request whenever it is empty or its byte
  // moves on to the parser in the same cycle, so a full stream runs at one
  // byte per clock. The parser only steps when the output buffer has room,
  // and that room is a registered fact, so m_axis_tready never reaches
  // s_axis_tready through logic.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       buf_space;

  assign advance       = in_valid && buf_space;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // The parser walks the header byte by byte, emits one descriptor once the
  // length and any masking key are in, then unmasks each payload byte.
  logic    emit;
  result_t res;

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .emit    (emit),
    .res     (res)
  );

  // Result register plus a skid entry, so a stalled consumer does not stop
  // the byte already in flight from landing.
  result_t out_res;

  wsd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && emit),
    .push_data (res),
    .space     (buf_space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.payload, out_res.length, out_res.masked,
                         out_res.opcode, out_res.fin};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  // A held byte with a full output buffer must block new requests.
  `ASSERT_SAME(a_block_when_full, clk, rst, in_valid && !buf_space, !s_axis_tready)
  // A descriptor marks the frame end exactly when its length is zero.
  `ASSERT_SAME(a_desc_last, clk, rst, advance && emit && (res.kind == KIND_DESC), res.last == (res.length == 64'd0))
  // Bytes of an unmasked frame pass through unchanged.
  `ASSERT_SAME(a_plain_payload, clk, rst, advance && emit && (res.kind == KIND_PAYLOAD) && !res.masked, res.payload == in_byte)
  // A stalled result stays on the output.
  `ASSERT_NEXT(a_hold_output, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

[hdl/wsd_parser.sv]
// Header parser and payload unmasking state for the frame deframer.
`timescale 1ns / 1ps
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       in_byte,
  output logic             emit,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]  phase, phase_next;
  logic [3:0]  ext_left, ext_left_next;
  logic        held_fin, held_fin_next;
  logic [3:0]  held_opcode, held_opcode_next;
  logic        held_masked, held_masked_next;
  logic [63:0] length_acc, length_acc_next;
  logic [31:0] mask_key, mask_key_next;
  logic [63:0] remaining, remaining_next;
  logic [1:0]  key_index, key_index_next;

  logic        desc;
  logic [3:0]  ext_dec;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;

  assign ext_dec = ext_left - 4'd1;
  assign rem_dec = remaining - 64'd1;

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next       = phase;
    ext_left_next    = ext_left;
    held_fin_next    = held_fin;
    held_opcode_next = held_opcode;
    held_masked_next = held_masked;
    length_acc_next  = length_acc;
    mask_key_next    = mask_key;
    remaining_next   = remaining;
    key_index_next   = key_index;
    desc             = 1'b0;
    emit             = 1'b0;

    res.kind    = KIND_DESC;
    res.fin     = held_fin;
    res.opcode  = held_opcode;
    res.masked  = held_masked;
    res.length  = length_acc;
    res.payload = 8'd0;
    res.last    = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        held_masked_next = in_byte[7];
        mask_key_next    = 32'd0;
        length_acc_next  = 64'd0;
        if (in_byte[6:0] == LEN_EXT16) begin
          ext_left_next = 4'd2;
          phase_next    = PH_EXTLEN;
        end else if (in_byte[6:0] == LEN_EXT64) begin
          ext_left_next = 4'd8;
          phase_next    = PH_EXTLEN;
        end else begin
          length_acc_next = {57'd0, in_byte[6:0]};
          if (in_byte[7]) begin
            ext_left_next = 4'd4;
            phase_next    = PH_KEY;
          end else begin
            ext_left_next = 4'd0;
            desc          = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_acc_next = {length_acc[55:0], in_byte};
        ext_left_next   = ext_dec;
        if (ext_dec == 4'd0) begin
          if (held_masked) begin
            ext_left_next = 4'd4;
            phase_next    = PH_KEY;
          end else begin
            desc = 1'b1;
          end
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        ext_left_next = ext_dec;
        if (ext_dec == 4'd0) begin
          desc = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_index_next = key_index + 2'd1;
        remaining_next = rem_dec;
        emit           = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.payload    = held_masked ? (in_byte ^ key_byte) : in_byte;
        res.last       = (rem_dec == 64'd0);
        if (rem_dec == 64'd0) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        // The first header byte; unused phase codes land here as well.
        held_fin_next    = in_byte[7];
        held_opcode_next = in_byte[3:0];
        ext_left_next    = 4'd0;
        phase_next       = PH_HDR1;
      end
    endcase

    if (desc) begin
      emit           = 1'b1;
      res.masked     = held_masked_next;
      res.length     = length_acc_next;
      res.last       = (length_acc_next == 64'd0);
      remaining_next = length_acc_next;
      key_index_next = 2'd0;
      phase_next     = (length_acc_next == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      ext_left    <= 4'd0;
      held_fin    <= 1'b0;
      held_opcode <= 4'd0;
      held_masked <= 1'b0;
      length_acc  <= 64'd0;
      mask_key    <= 32'd0;
      remaining   <= 64'd0;
      key_index   <= 2'd0;
    end else if (step) begin
      phase       <= phase_next;
      ext_left    <= ext_left_next;
      held_fin    <= held_fin_next;
      held_opcode <= held_opcode_next;
      held_masked <= held_masked_next;
      length_acc  <= length_acc_next;
      mask_key    <= mask_key_next;
      remaining   <= remaining_next;
      key_index   <= key_index_next;
    end
  end

endmodule

[hdl/wsd_outbuf.sv]
// Two-entry result register with skid entry for the deframer output.
`timescale 1ns / 1ps
module wsd_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_data
);
  import wsd_pkg::*;

  logic [1:0] count;
  result_t    head;
  result_t    tail;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = head;
  assign space     = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (pop && !push) begin
            count <= 2'd0;
          end else if (push && !pop) begin
            count <= 2'd2;
          end
        end
        default: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          head <= push_data;
        end
      end
      2'd1: begin
        if (pop && push) begin
          head <= push_data;
        end else if (push) begin
          tail <= push_data;
        end
      end
      default: begin
        if (pop) begin
          head <= tail;
        end
      end
    endcase
  end

endmodule

[sim/ws_frame_checker.sv]
// Predicts deframer results from accepted stream bytes and compares them with the output stream.
`timescale 1ns / 1ps
module ws_frame_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [wsd_pkg::TDATA_W-1:0] m_axis_tdata,
  input  logic                        m_axis_tuser,
  input  logic                        m_axis_tlast,
  output int                          fail_count,
  output int                          outstanding
);
  import wsd_pkg::*;

  localparam logic [6:0] LEN_ESC16 = 7'd126;
  localparam logic [6:0] LEN_ESC64 = 7'd127;
  localparam int         REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } parse_phase_e;

  parse_phase_e phase;
  logic [3:0]   bytes_left;
  logic         hdr_fin;
  logic [3:0]   hdr_opcode;
  logic         hdr_masked;
  logic [63:0]  hdr_length;
  logic [31:0]  mask_key;
  logic [63:0]  body_left;
  logic [1:0]   key_pos;

  result_t deframed_due[$];

  function automatic result_t make_result(input logic kind, input logic [7:0] data,
                                          input logic last);
    result_t r;
    r.kind    = kind;
    r.fin     = hdr_fin;
    r.opcode  = hdr_opcode;
    r.masked  = hdr_masked;
    r.length  = hdr_length;
    r.payload = data;
    r.last    = last;
    return r;
  endfunction

  // Header complete: announce the frame and arm the payload counter.
  task automatic open_payload();
    logic last;
    last      = (hdr_length == 64'd0);
    body_left = hdr_length;
    key_pos   = 2'd0;
    phase     = last ? PH_HDR0 : PH_PAYLOAD;
    deframed_due.push_back(make_result(KIND_DESC, 8'h00, last));
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       last;
    case (phase)
      PH_HDR1: begin
        hdr_masked = b[7];
        mask_key   = 32'd0;
        hdr_length = 64'd0;
        if (b[6:0] == LEN_ESC16) begin
          bytes_left = 4'd2;
          phase      = PH_EXTLEN;
        end else if (b[6:0] == LEN_ESC64) begin
          bytes_left = 4'd8;
          phase      = PH_EXTLEN;
        end else begin
          hdr_length = {57'd0, b[6:0]};
          if (hdr_masked) begin
            bytes_left = 4'd4;
            phase      = PH_KEY;
          end else begin
            bytes_left = 4'd0;
            open_payload();
          end
        end
      end
      PH_EXTLEN: begin
        hdr_length = {hdr_length[55:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) begin
          if (hdr_masked) begin
            bytes_left = 4'd4;
            phase      = PH_KEY;
          end else begin
            open_payload();
          end
        end
      end
      PH_KEY: begin
        mask_key   = {mask_key[23:0], b};
        bytes_left = bytes_left - 4'd1;
        if (bytes_left == 4'd0) open_payload();
      end
      PH_PAYLOAD: begin
        kb        = hdr_masked ? mask_key[31 - 8 * key_pos -: 8] : 8'h00;
        key_pos   = key_pos + 2'd1;
        body_left = body_left - 64'd1;
        last      = (body_left == 64'd0);
        if (last) phase = PH_HDR0;
        deframed_due.push_back(make_result(KIND_PAYLOAD, b ^ kb, last));
      end
      default: begin
        // The first header byte; reserved bits are dropped.
        hdr_fin    = b[7];
        hdr_opcode = b[3:0];
        bytes_left = 4'd0;
        phase      = PH_HDR1;
      end
    endcase
  endtask

  task automatic check_output();
    result_t want;
    result_t got;
    logic [1:0] pad;
    got.kind    = m_axis_tuser;
    got.fin     = m_axis_tdata[0];
    got.opcode  = m_axis_tdata[4:1];
    got.masked  = m_axis_tdata[5];
    got.length  = m_axis_tdata[69:6];
    got.payload = m_axis_tdata[77:70];
    got.last    = m_axis_tlast;
    pad         = m_axis_tdata[79:78];
    if (deframed_due.size() == 0) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t: result with none due: kind %0d length %h byte %h last %0d",
                 $realtime, got.kind, got.length, got.payload, got.last);
      fail_count++;
    end else begin
      want = deframed_due.pop_front();
      if (got.kind !== want.kind || got.fin !== want.fin || got.opcode !== want.opcode ||
          got.masked !== want.masked || got.length !== want.length ||
          got.payload !== want.payload || got.last !== want.last || pad !== 2'b00) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("%0t: mismatch (expected/actual) kind %0d/%0d fin %0d/%0d opcode %h/%h",
                   $realtime, want.kind, got.kind, want.fin, got.fin,
                   want.opcode, got.opcode);
          $display("  masked %0d/%0d length %h/%h byte %h/%h last %0d/%0d pad 0/%0d",
                   want.masked, got.masked, want.length, got.length,
                   want.payload, got.payload, want.last, got.last, pad);
        end
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_HDR0;
      bytes_left = 4'd0;
      hdr_fin    = 1'b0;
      hdr_opcode = 4'd0;
      hdr_masked = 1'b0;
      hdr_length = 64'd0;
      mask_key   = 32'd0;
      body_left  = 64'd0;
      key_pos    = 2'd0;
      deframed_due.delete();
    end else begin
      // A result leaving at this edge never comes from a byte taken at the same edge.
      if (m_axis_tvalid && m_axis_tready) check_output();
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
    end
    outstanding = deframed_due.size();
  end

endmodule

[sim/tb_websocket_frame_deframer.sv]
// Top of the deframer simulation: clock, reset, frame stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int FORM_7  = 0;
  localparam int FORM_16 = 1;
  localparam int FORM_64 = 2;

  localparam logic [6:0] LEN_ESC16 = 7'd126;
  localparam logic [6:0] LEN_ESC64 = 7'd127;

  localparam int PHASE_BYTES   = 130;
  localparam int LONG_HOLD     = 64;
  localparam int DRAIN_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  websocket_frame_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ws_frame_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side. A long hold-off, once requested, is counted down here so that
  // the sender keeps pushing bytes and the block backs up into its input.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("websocket_frame_deframer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // One frame: header, optional extended length, optional key, then body bytes.
  // The body count is separate from the length so a frame can be left open.
  task automatic send_frame(input logic [7:0] first, input logic masked, input int form,
                            input logic [63:0] length, input logic [31:0] key,
                            input int body);
    logic [6:0] len7;
    case (form)
      FORM_16: len7 = LEN_ESC16;
      FORM_64: len7 = LEN_ESC64;
      default: len7 = length[6:0];
    endcase
    send_byte(first);
    send_byte({masked, len7});
    if (form == FORM_16) begin
      send_byte(length[15:8]);
      send_byte(length[7:0]);
    end
    if (form == FORM_64)
      for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int i = 0; i < body; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Mostly short frames; the escaped forms often carry small, non-minimal lengths.
  task automatic send_random_frame();
    int          form;
    int          pick;
    logic [63:0] length;
    pick = $urandom_range(99);
    if (pick < 70) begin
      form   = FORM_7;
      length = ($urandom_range(9) == 0) ? 64'($urandom_range(125)) :
                                          64'($urandom_range(12));
    end else if (pick < 88) begin
      form   = FORM_16;
      length = ($urandom_range(9) == 0) ? 64'($urandom_range(300)) :
                                          64'($urandom_range(12));
    end else begin
      form   = FORM_64;
      length = 64'($urandom_range(12));
    end
    send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, length, $urandom,
               int'(length));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    int target;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 47;

    // Zero-length control frame with FIN and all reserved bits set.
    send_frame(8'hF9, 1'b0, FORM_7, 64'd0, 32'd0, 0);
    // Masked zero-length frame: the key is taken but no body follows.
    send_frame(8'h0A, 1'b1, FORM_7, 64'd0, 32'hA5C3_0F96, 0);
    // Unmasked body passes through unchanged.
    send_frame(8'h02, 1'b0, FORM_7, 64'd3, 32'd0, 3);
    // Non-minimal 16-bit length with an all-ones key.
    send_frame(8'h81, 1'b1, FORM_16, 64'd5, 32'hFFFF_FFFF, 5);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 0) begin
        // Stall the result side and keep offering a long body behind it.
        hold_requests++;
        send_frame(8'h82, 1'b1, FORM_7, 64'd40, $urandom, 40);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_random_frame();
      // Sender pauses until every due result has come out.
      wait_results_drained();
    end

    // Largest 64-bit length, top bit set: the frame stays open after its first bytes.
    send_frame(8'h82, 1'b1, FORM_64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 16);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("websocket_frame_deframer test passed");
    end else begin
      $display("websocket_frame_deframer test failed");
    end
    $finish;
  end

endmodule
